@@ design/axis_limit_sensor_qualifier_core_assert.svh @@
// Assertion macros for the axis limit sensor qualifier core
`ifndef AXIS_LIMIT_SENSOR_QUALIFIER_CORE_ASSERT_SVH
`define AXIS_LIMIT_SENSOR_QUALIFIER_CORE_ASSERT_SVH

// same-cycle implication
`define ALSQ_ASSERT_HOLDS(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ALSQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/alsq_pkg.sv @@
// Types and constants shared by the axis limit sensor qualifier
`timescale 1ns / 1ps

package alsq_pkg;

	localparam int PIN_W     = 4;
	localparam int CFG_IDX_W = 3;
	localparam int NUM_AXES  = 3;
	localparam int FLAGS_W   = 2 * NUM_AXES;

	localparam logic [7:0] INVERT_MASK = 8'h7F;

	// flag bit positions within one axis
	localparam int FLAG_START = 0;
	localparam int FLAG_STOP  = 1;

	typedef logic [PIN_W-1:0] pin_sel_t;
	typedef logic signed [1:0] dir_t;

	localparam dir_t DIR_POS = 2'sd1;

	typedef struct packed {
		pin_sel_t start_pin;
		pin_sel_t stop_pin;
	} axis_cfg_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_X_START = 3'd0,
		REG_X_STOP  = 3'd1,
		REG_Y_START = 3'd2,
		REG_Y_STOP  = 3'd3,
		REG_Z_START = 3'd4,
		REG_Z_STOP  = 3'd5
	} cfg_reg_t;

endpackage

@@ design/alsq_in_if.sv @@
// Input channel: status sample and axis directions
`timescale 1ns / 1ps

interface alsq_in_if import alsq_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] status_byte;
	dir_t       x_direction;
	dir_t       y_direction;
	dir_t       z_direction;

	modport source (
		output valid, status_byte, x_direction, y_direction, z_direction,
		input  ready
	);
	modport sink (
		input  valid, status_byte, x_direction, y_direction, z_direction,
		output ready
	);
endinterface

@@ design/alsq_out_if.sv @@
// Output channel: confirmation and limit flags
`timescale 1ns / 1ps

interface alsq_out_if ();
	logic valid;
	logic ready;
	logic sample_confirmed;
	logic x_at_start;
	logic x_at_stop;
	logic y_at_start;
	logic y_at_stop;
	logic z_at_start;
	logic z_at_stop;

	modport source (
		output valid, sample_confirmed, x_at_start, x_at_stop, y_at_start, y_at_stop,
			z_at_start, z_at_stop,
		input  ready
	);
	modport sink (
		input  valid, sample_confirmed, x_at_start, x_at_stop, y_at_start, y_at_stop,
			z_at_start, z_at_stop,
		output ready
	);
endinterface

@@ design/axis_limit_sensor_qualifier_core.sv @@
// Top level of the axis limit sensor qualifier
// Throughput: one beat per cycle; input register then result register.
// Back-pressure on the output stalls both stages; the input still takes a beat
// while the input register is empty.
// Reset clears pipeline valids, reference sample and flags; pin selections go to 8.
`timescale 1ns / 1ps

`include "axis_limit_sensor_qualifier_core_assert.svh"

module axis_limit_sensor_qualifier_core import alsq_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PIN_W-1:0]     cfg_data,
	alsq_in_if.sink              in_ch,
	alsq_out_if.source           out_ch
);

	axis_cfg_t          axis_cfg_q [NUM_AXES];
	logic [7:0]         ref_q;
	logic [FLAGS_W-1:0] flags_q;

	logic               valid_s1;
	logic [7:0]         status_s1;
	dir_t               dir_s1 [NUM_AXES];

	logic               valid_s2;
	logic               confirmed_s2;
	logic [FLAGS_W-1:0] flags_s2;

	logic               adv;
	logic [7:0]         sample;
	logic               confirmed;
	logic [FLAGS_W-1:0] flags_upd;
	logic [FLAGS_W-1:0] flags_next;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				axis_cfg_q[a].start_pin <= pin_sel_t'(8);
				axis_cfg_q[a].stop_pin  <= pin_sel_t'(8);
			end
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_X_START: axis_cfg_q[0].start_pin <= cfg_data;
				REG_X_STOP:  axis_cfg_q[0].stop_pin  <= cfg_data;
				REG_Y_START: axis_cfg_q[1].start_pin <= cfg_data;
				REG_Y_STOP:  axis_cfg_q[1].stop_pin  <= cfg_data;
				REG_Z_START: axis_cfg_q[2].start_pin <= cfg_data;
				REG_Z_STOP:  axis_cfg_q[2].stop_pin  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign adv         = !valid_s2 || out_ch.ready;
	assign in_ch.ready = !valid_s1 || adv;

	// stage 1: input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ch.ready)
			valid_s1 <= in_ch.valid;
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			status_s1 <= in_ch.status_byte;
			dir_s1[0] <= in_ch.x_direction;
			dir_s1[1] <= in_ch.y_direction;
			dir_s1[2] <= in_ch.z_direction;
		end
	end

	assign sample    = status_s1 ^ INVERT_MASK;
	assign confirmed = (sample == ref_q);

	for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
		alsq_axis_update u_axis (
			.sample    (sample),
			.cfg       (axis_cfg_q[a]),
			.direction (dir_s1[a]),
			.flags_in  (flags_q[2*a +: 2]),
			.flags_out (flags_upd[2*a +: 2])
		);
	end

	assign flags_next = confirmed ? flags_upd : flags_q;

	// state and stage 2: result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q    <= '0;
			flags_q  <= '0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				if (!confirmed)
					ref_q <= sample;
				flags_q <= flags_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			confirmed_s2 <= confirmed;
			flags_s2     <= flags_next;
		end
	end

	assign out_ch.valid            = valid_s2;
	assign out_ch.sample_confirmed = confirmed_s2;
	assign out_ch.x_at_start       = flags_s2[0];
	assign out_ch.x_at_stop        = flags_s2[1];
	assign out_ch.y_at_start       = flags_s2[2];
	assign out_ch.y_at_stop        = flags_s2[3];
	assign out_ch.z_at_start       = flags_s2[4];
	assign out_ch.z_at_stop        = flags_s2[5];

	`ALSQ_ASSERT_NEXT(a_unconf_keeps_flags, valid_s1 && adv && !confirmed, $stable(flags_q), "flags moved on unconfirmed sample")
	`ALSQ_ASSERT_NEXT(a_conf_keeps_ref, valid_s1 && adv && confirmed, $stable(ref_q), "reference moved on confirmed sample")
	`ALSQ_ASSERT_HOLDS(a_result_tracks_state, valid_s2, flags_s2 == flags_q, "held result disagrees with flag state")
	`ALSQ_ASSERT_HOLDS(a_ready_when_empty, !valid_s2, in_ch.ready, "input stalled with empty result stage")

endmodule

@@ design/alsq_axis_update.sv @@
// Start/stop flag update for one axis from a confirmed sample
`timescale 1ns / 1ps

module alsq_axis_update import alsq_pkg::*; (
	input  logic [7:0] sample,
	input  axis_cfg_t  cfg,
	input  dir_t       direction,
	input  logic [1:0] flags_in,
	output logic [1:0] flags_out
);

	logic start_asg;
	logic stop_asg;
	logic same_pin;
	logic start_lvl;
	logic stop_lvl;
	logic neg;
	logic pos;

	// selections of 8 and above are unassigned
	assign start_asg = !cfg.start_pin[PIN_W-1];
	assign stop_asg  = !cfg.stop_pin[PIN_W-1];
	assign same_pin  = (start_asg == stop_asg) &&
		(!start_asg || (cfg.start_pin[PIN_W-2:0] == cfg.stop_pin[PIN_W-2:0]));
	assign start_lvl = sample[cfg.start_pin[PIN_W-2:0]];
	assign stop_lvl  = sample[cfg.stop_pin[PIN_W-2:0]];
	assign neg       = direction[1];
	assign pos       = (direction == DIR_POS);

	always_comb begin
		flags_out = flags_in;
		if (!same_pin) begin
			if (start_asg)
				flags_out[FLAG_START] = start_lvl;
			if (stop_asg)
				flags_out[FLAG_STOP] = stop_lvl;
		end else if (start_asg) begin
			// shared pin: latch direction on engage, clear both on release
			if (start_lvl) begin
				if (flags_in == 2'b00) begin
					flags_out[FLAG_START] = neg;
					flags_out[FLAG_STOP]  = pos;
				end
			end else begin
				flags_out = 2'b00;
			end
		end
	end

endmodule
